// ===== sv/ohs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ohs_pkg
// Shared types and constants of the open-addressed hash set.
// ---------------------------------------------------------------------------
package ohs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS    = 32;
    localparam int HASH_BITS   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int THR_W       = 7;
    localparam int PROD_W      = CNT_W + THR_W;
    localparam int HCNT_W      = $clog2(HASH_BITS);
    localparam int CFG_IDX_W   = 8;

    localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK
    } back_state_t;

    // one classified request between front and back
    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [IDX_W-1:0]    start;
        logic [CNT_W-1:0]    step;
    } item_t;

    // settings used by both halves
    typedef struct packed {
        logic [CNT_W-1:0] cap;
        logic [THR_W-1:0] thr;
    } cfg_t;

endpackage

// ===== sv/open_addressed_hash_set.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// open_addressed_hash_set
// Open-addressed key set with a growing probe step.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes requests: s_tuser is the operation (0 lookup,
//   1 insert), s_tdata carries the key and its precomputed hash.
//   m_* channel returns one result per request: m_tuser is the status
//   (inserted, refused, found, not found), m_tdata the slot and the count.
//   cfg_* writes capacity (index 0) and load threshold (index 1); write only
//   while no request is in flight. cfg_ready is always high.
// Flow: the front works out the two remainders (one hash bit per cycle);
//   the back then reads and checks each probed bucket (registered memory
//   read, then compare). An insert refused by the load threshold is
//   answered in the idle state without probing. The front takes a request
//   only after pushing the last; with short chains its divider sets the rate.
// Reset: aresetn low clears control state; afterwards all 1024 buckets are
//   swept empty, during which s_tready stays low.
// Stall: a held result stays in the output register; the front and the
//   two-entry queue keep accepting until the queue is full.
// ---------------------------------------------------------------------------
module open_addressed_hash_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], key_hash [63:32]
    input  logic [0:0]  s_tuser,   // operation [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slot_index [9:0], entry_total [20:10], zero [23:21]
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ohs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [10:0] cfg_data
);
    import ohs_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    logic [THR_W-1:0] thr_reg;
    cfg_t             cfg;
    logic             clearing;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    item_t            push_item, pop_item;
    status_t          res_status;
    logic [IDX_W-1:0] res_slot;
    logic [CNT_W-1:0] res_total;

    assign cfg_ready = 1'b1;

    // hold the raw register values; the clamp is applied on use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(1024);
            thr_reg <= THR_W'(70);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CAPACITY:  cap_reg <= cfg_data[CNT_W-1:0];
                REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp capacity into 2..TABLE_DEPTH
    always_comb begin
        cfg.thr = thr_reg;
        if (cap_reg < CNT_W'(2))                cfg.cap = CNT_W'(2);
        else if (cap_reg > CNT_W'(TABLE_DEPTH)) cfg.cap = CNT_W'(TABLE_DEPTH);
        else                                    cfg.cap = cap_reg;
    end

    ohs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .hold       (clearing),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser[0])),
        .in_key     (s_tdata[KEY_BITS-1:0]),
        .in_hash    (s_tdata[KEY_BITS+HASH_BITS-1:KEY_BITS]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ohs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ohs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .clearing   (clearing),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_slot   (res_slot),
        .res_total  (res_total)
    );

    assign m_tuser = res_status;
    assign m_tdata = {3'b000, res_total, res_slot};

endmodule

// ===== sv/ohs_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ohs_front
// Accepts requests and works out the first bucket and the probe step.
// ---------------------------------------------------------------------------
module ohs_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ohs_pkg::cfg_t                cfg,
    input  logic                         hold,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ohs_pkg::op_t                 in_op,
    input  logic [ohs_pkg::KEY_BITS-1:0] in_key,
    input  logic [ohs_pkg::HASH_BITS-1:0] in_hash,
    output logic                         push_valid,
    input  logic                         push_ready,
    output ohs_pkg::item_t               push_item
);
    import ohs_pkg::*;

    front_state_t           state_reg, state_next;
    op_t                    op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HASH_BITS-1:0]   hash_reg, hash_next;
    logic [HCNT_W-1:0]      bit_reg, bit_next;
    logic [CNT_W-1:0]       rem1_reg, rem1_next, rem2_reg, rem2_next;
    logic [CNT_W:0]         t1, t2;
    logic [CNT_W-1:0]       div2;

    assign div2 = cfg.cap - CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid && in_ready) state_next = F_DIV;
            F_DIV:  if (bit_reg == '0) state_next = F_PUSH;
            F_PUSH: if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // one remainder bit per cycle for both divisors
    always_comb begin
        t1 = {rem1_reg, hash_reg[HASH_BITS-1]};
        t2 = {rem2_reg, hash_reg[HASH_BITS-1]};
        if (t1 >= {1'b0, cfg.cap}) t1 = t1 - {1'b0, cfg.cap};
        if (t2 >= {1'b0, div2}) t2 = t2 - {1'b0, div2};
        rem1_next = rem1_reg;
        rem2_next = rem2_reg;
        hash_next = hash_reg;
        bit_next  = bit_reg;
        if (state_reg == F_IDLE) begin
            rem1_next = '0;
            rem2_next = '0;
            hash_next = in_hash;
            bit_next  = HCNT_W'(HASH_BITS - 1);
        end else if (state_reg == F_DIV) begin
            rem1_next = t1[CNT_W-1:0];
            rem2_next = t2[CNT_W-1:0];
            hash_next = hash_reg << 1;
            bit_next  = bit_reg - HCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem1_reg <= rem1_next;
        rem2_reg <= rem2_next;
        hash_reg <= hash_next;
        bit_reg  <= bit_next;
        if (in_valid && in_ready) begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
    end

    assign in_ready        = (state_reg == F_IDLE) && !hold;
    assign push_valid      = (state_reg == F_PUSH);
    assign push_item.op    = op_reg;
    assign push_item.key   = key_reg;
    assign push_item.start = rem1_reg[IDX_W-1:0];
    assign push_item.step  = rem2_reg + CNT_W'(1);

endmodule

// ===== sv/ohs_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ohs_queue
// Two-entry queue of classified requests.
// ---------------------------------------------------------------------------
module ohs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  ohs_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ohs_pkg::item_t pop_item
);
    import ohs_pkg::*;

    item_t      buf_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] fill_reg;
    logic       do_push, do_pop;

    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = buf_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (do_push) wr_reg <= ~wr_reg;
            if (do_pop)  rd_reg <= ~rd_reg;
            fill_reg <= fill_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) buf_reg[wr_reg] <= push_item;
    end

endmodule

// ===== sv/ohs_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ohs_back
// Probes the bucket memory, stores keys and holds the result register.
// ---------------------------------------------------------------------------
module ohs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ohs_pkg::cfg_t                 cfg,
    output logic                          clearing,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  ohs_pkg::item_t                pop_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ohs_pkg::status_t              res_status,
    output logic [ohs_pkg::IDX_W-1:0]     res_slot,
    output logic [ohs_pkg::CNT_W-1:0]     res_total
);
    import ohs_pkg::*;

    back_state_t         state_reg, state_next;
    logic [KEY_BITS:0]   mem [TABLE_DEPTH];
    logic [KEY_BITS:0]   rd_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_addr;
    logic [KEY_BITS:0]   mem_wd;

    logic [IDX_W-1:0]    clr_reg, clr_next;
    op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                res_valid_reg, res_valid_next;
    status_t             status_reg, status_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    total_reg, total_next;

    logic                refused, hit, miss, give_up;
    logic [CNT_W:0]      sum;
    logic [PROD_W-1:0]   need, limit;

    assign pop_ready = (state_reg == B_IDLE) && (!res_valid_reg || res_ready);
    assign clearing  = (state_reg == B_CLEAR);

    assign need    = PROD_W'(count_reg + CNT_W'(1)) * PCT_SCALE;
    assign limit   = PROD_W'(cfg.cap) * PROD_W'(cfg.thr);
    assign refused = (pop_item.op == OP_INSERT) && (need >= limit);
    assign miss    = !rd_reg[KEY_BITS];
    assign hit     = !miss && (op_reg == OP_LOOKUP) && (rd_reg[KEY_BITS-1:0] == key_reg);
    assign give_up = (n_reg == cfg.cap - CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR: if (clr_reg == IDX_W'(TABLE_DEPTH - 1)) state_next = B_IDLE;
            B_IDLE:  if (pop_valid && pop_ready && !refused) state_next = B_READ;
            B_READ:  state_next = B_CHECK;
            B_CHECK: if (miss || hit || give_up) state_next = B_IDLE;
                     else state_next = B_READ;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        clr_next       = clr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg && !res_ready;
        mem_we         = 1'b0;
        mem_addr       = idx_reg;
        mem_wd         = {1'b1, key_reg};
        sum            = {1'b0, CNT_W'(idx_reg)} + {1'b0, step_reg};
        if (sum >= {1'b0, cfg.cap}) sum = sum - {1'b0, cfg.cap};
        unique case (state_reg)
            B_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                mem_wd   = '0;
                clr_next = clr_reg + IDX_W'(1);
            end
            B_IDLE: begin
                if (pop_valid && pop_ready) begin
                    op_next   = pop_item.op;
                    key_next  = pop_item.key;
                    idx_next  = pop_item.start;
                    step_next = pop_item.step;
                    n_next    = '0;
                    if (refused) begin
                        res_valid_next = 1'b1;
                        status_next    = ST_REFUSED;
                        slot_next      = '0;
                        total_next     = count_reg;
                    end
                end
            end
            B_READ: begin
            end
            B_CHECK: begin
                if (miss || hit || give_up) begin
                    res_valid_next = 1'b1;
                    slot_next      = '0;
                    total_next     = count_reg;
                    status_next    = (op_reg == OP_INSERT) ? ST_REFUSED : ST_NOT_FOUND;
                    if (miss && op_reg == OP_INSERT) begin
                        mem_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        total_next  = count_reg + CNT_W'(1);
                        status_next = ST_INSERTED;
                        slot_next   = idx_reg;
                    end else if (hit) begin
                        status_next = ST_FOUND;
                        slot_next   = idx_reg;
                    end
                end else begin
                    n_next = n_reg + CNT_W'(1);
                    if (n_reg == '0) begin
                        idx_next = step_reg[IDX_W-1:0];
                    end else begin
                        idx_next  = sum[IDX_W-1:0];
                        step_next = (step_reg == cfg.cap) ? CNT_W'(1) : step_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        total_reg  <= total_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        rd_reg <= mem[mem_addr];
    end

    assign res_valid  = res_valid_reg;
    assign res_status = status_reg;
    assign res_slot   = slot_reg;
    assign res_total  = total_reg;

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_READ |-> CNT_W'(idx_reg) < cfg.cap)
        else $error("probe bucket beyond capacity");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("stored count above table depth");
    a_count_from_check: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> $past(state_reg) == B_CHECK)
        else $error("count moved outside a bucket check");
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_CLEAR |-> !pop_ready)
        else $error("request taken during clear");

endmodule
